@@ design/lowest_free_id_allocator_top_macros.svh @@
// Assertion macros shared by the ID allocator RTL.
// Every macro samples on clk_i; the reset-guarded form is disabled while rst_ni is low.
`ifndef LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_TOP_MACROS_SVH

// Concurrent check that is ignored while reset is asserted.
`define LFA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define LFA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/lfa_pkg.sv @@
// Shared types, constants and bit-scan helpers for the lowest free ID allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lfa_pkg;

  // Free marks are stored as words of this many bits.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LOG_W  = 5;
  localparam int unsigned POS1_W = LOG_W + 1;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned CNT_W  = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // How the datapath updates the mark RAM word address.
  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_HW,
    ADDR_SLOT,
    ADDR_TRIM,
    ADDR_NEXT,
    ADDR_PREV
  } addr_sel_e;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FULL,
    OP_IGNORE,
    OP_RELEASE,
    OP_REL_TOP,
    OP_SCAN,
    OP_TOP_ALLOC,
    OP_REL_SET,
    OP_TRIM
  } op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic      load;
    logic      emit;
    addr_sel_e addr_sel;
    op_e       op;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_alloc;
    logic recyc;
    logic free_avail;
    logic hw_full;
    logic slot_ok;
    logic slot_top;
    logic hw_one;
    logic scan_hit;
    logic trim_more;
    logic out_free;
  } stat_t;

  // Mask with the lowest n bits set; n may be up to WORD_W.
  function automatic logic [WORD_W-1:0] low_mask(input logic [POS1_W-1:0] n);
    logic [WORD_W-1:0] m;
    if (n >= POS1_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << n) - WORD_W'(1);
    end
    return m;
  endfunction

  // Index of the lowest set bit.
  function automatic logic [LOG_W-1:0] lsb_index(input logic [WORD_W-1:0] w);
    logic [LOG_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = LOG_W'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit.
  function automatic logic [LOG_W-1:0] msb_index(input logic [WORD_W-1:0] w);
    logic [LOG_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) idx = LOG_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/lfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
`default_nettype none

module lfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/lfa_ctrl.sv @@
// Sequencing state machine of the ID allocator.
// Depends on lfa_pkg for the command and status structs.
`default_nettype none

module lfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lfa_pkg::stat_t stat_i,
  output lfa_pkg::cmd_t      cmd_o
);

  import lfa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_TOP    = 3'd3;
  localparam logic [2:0] S_REL    = 3'd4;
  localparam logic [2:0] S_TRIM   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.addr_sel = ADDR_HOLD;
    cmd_o.op       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_alloc) begin
          if (stat_i.free_avail) begin
            cmd_o.addr_sel = ADDR_ZERO;
            state_d        = S_SCAN;
          end else if (!stat_i.hw_full) begin
            cmd_o.addr_sel = ADDR_HW;
            state_d        = S_TOP;
          end else begin
            cmd_o.op = OP_FULL;
            state_d  = S_DONE;
          end
        end else if (!stat_i.slot_ok) begin
          cmd_o.op = OP_IGNORE;
          state_d  = S_DONE;
        end else if (!stat_i.recyc) begin
          cmd_o.op = OP_RELEASE;
          state_d  = S_DONE;
        end else if (stat_i.slot_top) begin
          // The top slot comes back: lower the mark, then walk down over free slots.
          cmd_o.op = OP_REL_TOP;
          if (stat_i.hw_one) begin
            state_d = S_DONE;
          end else begin
            cmd_o.addr_sel = ADDR_TRIM;
            state_d        = S_TRIM;
          end
        end else begin
          cmd_o.addr_sel = ADDR_SLOT;
          state_d        = S_REL;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_hit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.addr_sel = ADDR_NEXT;
        end
      end
      S_TOP: begin
        cmd_o.op = OP_TOP_ALLOC;
        state_d  = S_DONE;
      end
      S_REL: begin
        cmd_o.op = OP_REL_SET;
        state_d  = S_DONE;
      end
      S_TRIM: begin
        cmd_o.op = OP_TRIM;
        if (stat_i.trim_more) begin
          cmd_o.addr_sel = ADDR_PREV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/lfa_dp.sv @@
// Datapath of the ID allocator: free-mark RAM, high-water mark, counters, result register.
// Depends on lfa_pkg, lfa_ram and the assertion macro header.
`default_nettype none
`include "lowest_free_id_allocator_top_macros.svh"

module lfa_dp #(
  parameter int unsigned POOL_SIZE = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [31:0]           cfg_wdata_i,
  input  wire logic [39:0]           item_data_i,
  input  wire logic                  item_kind_i,
  input  wire logic                  res_ready_i,
  output logic                       res_valid_o,
  output logic      [63:0]           res_data_o,
  output logic      [1:0]            res_status_o,
  input  wire lfa_pkg::cmd_t         cmd_i,
  output lfa_pkg::stat_t             stat_o
);

  import lfa_pkg::*;

  localparam int unsigned HW_W  = $clog2(POOL_SIZE + 1);
  localparam int unsigned WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SW    = HW_W + LOG_W + 1;

  // Item and configuration registers.
  logic [ID_W-1:0]   offset_q;
  logic              kind_q;
  logic              recyc_q;
  logic [ID_W-1:0]   slot_q;

  // Allocation state.
  logic [HW_W-1:0]   hw_q, hw_d;
  logic [HW_W-1:0]   free_q, free_d;
  logic [CNT_W-1:0]  alloc_q, alloc_d;
  logic [AW-1:0]     addr_q, addr_d;

  // Pending result and output register.
  logic [ID_W-1:0]   res_id_q, res_id_d;
  status_e           res_st_q, res_st_d;
  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q;
  status_e           out_st_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_free;

  // RAM port signals.
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // Scan and trim helpers.
  logic [SW-1:0]     hw_ext;
  logic [SW-1:0]     base_ext;
  logic [SW-1:0]     lim;
  logic [POS1_W-1:0] lim_cl;
  logic [WORD_W-1:0] scan_bits;
  logic              scan_hit;
  logic [LOG_W-1:0]  scan_pos;
  logic [SW-1:0]     scan_slot;
  logic [LOG_W-1:0]  top_pos;
  logic [POS1_W-1:0] hb;
  logic [WORD_W-1:0] trim_inv;
  logic              trim_hit;
  logic [LOG_W-1:0]  trim_j;
  logic [HW_W-1:0]   trim_hw;
  logic [POS1_W-1:0] removed;
  logic [LOG_W-1:0]  rel_pos;
  logic [LOG_W-1:0]  hw_pos;
  logic [CNT_W-1:0]  alloc_inc;

  // Free-mark storage, one bit per pool slot.
  lfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  // Scan of one word for the lowest free slot below the high-water mark.
  always_comb begin
    hw_ext    = SW'(hw_q);
    base_ext  = SW'(addr_q) << LOG_W;
    lim       = hw_ext - base_ext;
    lim_cl    = (lim >= SW'(WORD_W)) ? POS1_W'(WORD_W) : POS1_W'(lim);
    scan_bits = ram_rdata & low_mask(lim_cl);
    scan_hit  = |scan_bits;
    scan_pos  = lsb_index(scan_bits);
    scan_slot = base_ext + SW'(scan_pos);
  end

  // Trim step: find the highest allocated slot below the current top in this word.
  always_comb begin
    top_pos  = LOG_W'(hw_q - HW_W'(1));
    hb       = {1'b0, top_pos} + POS1_W'(1);
    trim_inv = ~ram_rdata & low_mask(hb);
    trim_hit = |trim_inv;
    trim_j   = msb_index(trim_inv);
    if (trim_hit) begin
      trim_hw = HW_W'(base_ext + SW'(trim_j) + SW'(1));
      removed = hb - POS1_W'(1) - {1'b0, trim_j};
    end else begin
      trim_hw = HW_W'(base_ext);
      removed = hb;
    end
  end

  assign rel_pos   = LOG_W'(slot_q);
  assign hw_pos    = LOG_W'(hw_q);
  assign alloc_inc = (alloc_q == '1) ? alloc_q : alloc_q + CNT_W'(1);
  assign out_free  = !out_valid_q || res_ready_i;

  // Word address of the mark RAM.
  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_HOLD: addr_d = addr_q;
      ADDR_ZERO: addr_d = '0;
      ADDR_HW:   addr_d = AW'(hw_q >> LOG_W);
      ADDR_SLOT: addr_d = AW'(slot_q >> LOG_W);
      ADDR_TRIM: addr_d = AW'((hw_q - HW_W'(2)) >> LOG_W);
      ADDR_NEXT: addr_d = addr_q + AW'(1);
      ADDR_PREV: addr_d = addr_q - AW'(1);
      default:   addr_d = addr_q;
    endcase
  end

  // State updates and RAM writes for each operation.
  always_comb begin
    hw_d      = hw_q;
    free_d    = free_q;
    alloc_d   = alloc_q;
    res_id_d  = res_id_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    case (cmd_i.op)
      OP_FULL: begin
        res_id_d = '0;
        res_st_d = ST_FULL;
      end
      OP_IGNORE: begin
        res_id_d = '0;
        res_st_d = ST_IGNORED;
      end
      OP_RELEASE: begin
        res_id_d = '0;
        res_st_d = ST_RELEASED;
      end
      OP_REL_TOP: begin
        hw_d     = hw_q - HW_W'(1);
        res_id_d = '0;
        res_st_d = ST_RELEASED;
      end
      OP_SCAN: begin
        if (scan_hit) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(WORD_W'(1) << scan_pos);
          free_d    = free_q - HW_W'(1);
          alloc_d   = alloc_inc;
          res_id_d  = offset_q + ID_W'(1) + ID_W'(scan_slot);
          res_st_d  = ST_ALLOCATED;
        end
      end
      OP_TOP_ALLOC: begin
        // A fresh slot enters the pool; its mark may hold stale data, so clear it.
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << hw_pos);
        hw_d      = hw_q + HW_W'(1);
        alloc_d   = alloc_inc;
        res_id_d  = offset_q + ID_W'(1) + ID_W'(hw_q);
        res_st_d  = ST_ALLOCATED;
      end
      OP_REL_SET: begin
        if (!ram_rdata[rel_pos]) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_W'(1) << rel_pos);
          free_d    = free_q + HW_W'(1);
        end
        res_id_d = '0;
        res_st_d = ST_RELEASED;
      end
      OP_TRIM: begin
        hw_d   = trim_hw;
        free_d = free_q - HW_W'(removed);
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    stat_o.is_alloc   = !kind_q;
    stat_o.recyc      = recyc_q;
    stat_o.free_avail = (free_q != '0);
    stat_o.hw_full    = (hw_q == HW_W'(POOL_SIZE));
    stat_o.slot_ok    = (slot_q < ID_W'(hw_q));
    stat_o.slot_top   = (slot_q == ID_W'(hw_q) - ID_W'(1));
    stat_o.hw_one     = (hw_q == HW_W'(1));
    stat_o.scan_hit   = scan_hit;
    stat_o.trim_more  = !trim_hit && (addr_q != '0);
    stat_o.out_free   = out_free;
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      hw_q        <= '0;
      free_q      <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      hw_q    <= hw_d;
      free_q  <= free_d;
      alloc_q <= alloc_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
    if (cmd_i.load) begin
      kind_q  <= item_kind_i;
      recyc_q <= item_data_i[32];
      slot_q  <= item_data_i[31:0] - offset_q - ID_W'(1);
    end
    if (cmd_i.emit) begin
      out_id_q  <= res_id_q;
      out_st_q  <= res_st_q;
      out_cnt_q <= alloc_q;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_data_o   = {out_cnt_q, out_id_q};
  assign res_status_o = out_st_q;

  // Checks on the allocation bookkeeping.
  `LFA_ASSERT(a_free_le_hw, free_q <= hw_q, "free count exceeds the high-water mark")
  `LFA_ASSERT(a_hw_in_pool, hw_q <= HW_W'(POOL_SIZE), "high-water mark beyond the pool")
  `LFA_ASSERT(a_scan_in_range, (cmd_i.op == OP_SCAN) |-> (base_ext < hw_ext), "scan passed the top")
  `LFA_ASSERT(a_alloc_mono, 1'b1 |=> (alloc_q >= $past(alloc_q)), "allocation count went down")
  `LFA_ASSERT(a_emit_free, cmd_i.emit |-> out_free, "result overwrote a pending beat")

endmodule

`default_nettype wire

@@ design/lowest_free_id_allocator_top.sv @@
// Top level of the lowest free ID allocator: stream ports, controller and datapath.
// Depends on lfa_pkg, lfa_ctrl and lfa_dp.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: kind; tdata: release_id[31:0], recyclable[32]
//   m_axis    out        tuser: status; tdata: granted_id[31:0], total_allocations[63:32]
//   cfg       in         cfg_wdata_i: id_offset, written when cfg_we_i is high
//
// One item at a time. Allocation of a fresh top ID, and a release that is not at the top,
// pass through S_DECODE, S_TOP or S_REL, and S_DONE; full pool, ignored and non-recyclable
// releases go from S_DECODE to S_DONE. Allocation from the free set scans the 32-bit mark
// words, and a release of the top ID walks the words down while trimming; the single read
// port of the mark RAM sets both walks. Reset needs no clearing pass: the high-water mark
// bounds the valid marks. A stalled output holds its beat while the next item is taken.
`default_nettype none

module lowest_free_id_allocator_top #(
  parameter int unsigned POOL_SIZE = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: id_offset.
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Request stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [31:0] release_id, [32] recyclable, rest zero
  input  wire logic        s_axis_tuser,   // [0] kind
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,   // [31:0] granted_id, [63:32] total_allocations
  output logic      [1:0]  m_axis_tuser    // [1:0] status
);

  lfa_pkg::cmd_t  cmd;
  lfa_pkg::stat_t stat;

  // Sequencer.
  lfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Mark storage, counters and result register.
  lfa_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_data_i  (s_axis_tdata),
    .item_kind_i  (s_axis_tuser),
    .res_ready_i  (m_axis_tready),
    .res_valid_o  (m_axis_tvalid),
    .res_data_o   (m_axis_tdata),
    .res_status_o (m_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

`default_nettype wire
